// ===== design/bps_pkg.sv =====
// Shared constants, status codes, arctangent table and stage sideband types
// for the ballistic pitch solver. No dependencies.
package bps_pkg;

  localparam logic [15:0] GRAV_RESET = 16'd40072;  // 9.7833 m/s^2 in Q4.12
  localparam logic [15:0] INV_GAIN   = 16'd39797;  // inverse CORDIC gain, Q0.16
  localparam int PITCH_LIMIT  = 25736;

  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int QUO_BITS     = 16;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int P_W    = 34;
  localparam int N_W    = 54;
  localparam int XY_W   = 58;
  localparam int Z_W    = 19;
  localparam int DEN_W  = 50;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;
  localparam logic [1:0] ST_OVF     = 2'd3;

  function automatic logic [15:0] atan_q16(input int idx);
    logic [15:0] a;
    case (idx)
      0: a = 16'd51472;
      1: a = 16'd30386;
      2: a = 16'd16055;
      3: a = 16'd8150;
      4: a = 16'd4091;
      5: a = 16'd2047;
      6: a = 16'd1024;
      7: a = 16'd512;
      8: a = 16'd256;
      9: a = 16'd128;
      10: a = 16'd64;
      11: a = 16'd32;
      12: a = 16'd16;
      13: a = 16'd8;
      14: a = 16'd4;
      15: a = 16'd2;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic [1:0]            status;
    logic [15:0]           speed;
    logic [15:0]           range_m;
    logic [31:0]           v2;
    logic signed [N_W-1:0] n28;
  } sqrt_side_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DEN_W-1:0] den;
  } cordic_side_t;

endpackage

// ===== design/bps_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on bps_pkg.
module bps_isqrt import bps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  sqrt_side_t        side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output sqrt_side_t        side_o
);

  logic              vld_q  [SQRT_STEPS];
  logic [RAD_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];
  sqrt_side_t        side_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
    localparam int K = SQRT_STEPS - 1 - i;
    logic              vin;
    logic [RAD_W-1:0]  rin;
    logic [ROOT_W-1:0] qin;
    sqrt_side_t        sin;
    logic [RAD_W:0]    trial;
    logic              take;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rad_i;
      assign qin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[i-1];
      assign rin = rem_q[i-1];
      assign qin = root_q[i-1];
      assign sin = side_q[i-1];
    end

    // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
    assign trial = ({{(RAD_W+1-ROOT_W){1'b0}}, qin} << (K + 1))
                 + ((RAD_W+1)'(1) << (2 * K));
    assign take  = {1'b0, rin} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= take ? rin - trial[RAD_W-1:0] : rin;
        root_q[i] <= take ? (qin | (ROOT_W'(1) << K)) : qin;
        side_q[i] <= sin;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign root_o  = root_q[SQRT_STEPS-1];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

// ===== design/bps_cordic.sv =====
// Pipelined CORDIC in vectoring mode, one rotation per stage.
// Depends on bps_pkg.
module bps_cordic import bps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  cordic_side_t           side_i,
  output logic                   valid_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [Z_W-1:0]  z_o,
  output cordic_side_t           side_o
);

  logic                   vld_q  [CORDIC_STEPS];
  logic signed [XY_W-1:0] x_q    [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_q    [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_q    [CORDIC_STEPS];
  cordic_side_t           side_q [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    logic                   vin;
    logic signed [XY_W-1:0] xin, yin, dx, dy;
    logic signed [Z_W-1:0]  zin, ang;
    cordic_side_t           sin;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign xin = x_i;
      assign yin = y_i;
      assign zin = '0;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[i-1];
      assign xin = x_q[i-1];
      assign yin = y_q[i-1];
      assign zin = z_q[i-1];
      assign sin = side_q[i-1];
    end

    assign dx  = yin >>> i;
    assign dy  = xin >>> i;
    assign ang = $signed({{(Z_W-16){1'b0}}, atan_q16(i)});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!yin[XY_W-1]) begin
          x_q[i] <= xin + dx;
          y_q[i] <= yin - dy;
          z_q[i] <= zin + ang;
        end else begin
          x_q[i] <= xin - dx;
          y_q[i] <= yin + dy;
          z_q[i] <= zin - ang;
        end
        side_q[i] <= sin;
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STEPS-1];
  assign x_o     = x_q[CORDIC_STEPS-1];
  assign z_o     = z_q[CORDIC_STEPS-1];
  assign side_o  = side_q[CORDIC_STEPS-1];

endmodule

// ===== design/ballistic_pitch_solver_core.sv =====
// Pipeline from input beat to result beat: 3 front stages, 32 square
// root stages, 2 set-up stages, 16 CORDIC stages, 3 scaling stages, 16 divider
// stages. Throughput: one beat per cycle; the whole pipeline holds while the
// output register is full and not taken. Reset clears all valid bits and loads
// gravity with 9.7833 m/s^2. Top level; depends on bps_pkg, bps_isqrt, bps_cordic.
module ballistic_pitch_solver_core import bps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // gravity register, Q4.12
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] muzzle_speed, [31:16] horizontal_distance, [47:32] target_height
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] pitch_angle, [31:16] flight_time
  output logic [31:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  logic [15:0] grav_q;
  logic        en;
  logic        out_vld;

  // Advance everything unless a finished beat waits at the output.
  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAV_RESET;
    end else if (cfg_we_i) begin
      grav_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage 1: narrow products ----------------
  logic [15:0]        in_v, in_d, in_habs;
  logic signed [15:0] in_h;
  assign in_v    = s_axis_tdata[15:0];
  assign in_d    = s_axis_tdata[31:16];
  assign in_h    = $signed(s_axis_tdata[47:32]);
  assign in_habs = in_h[15] ? 16'(-in_h) : in_h;

  logic               s1_vld_q;
  logic [15:0]        s1_v_q, s1_d_q;
  logic signed [15:0] s1_h_q;
  logic [31:0]        s1_v2_q, s1_gd_q, s1_gh_q;
  logic [1:0]         s1_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v_q  <= in_v;
      s1_d_q  <= in_d;
      s1_h_q  <= in_h;
      s1_v2_q <= in_v * in_v;
      s1_gd_q <= grav_q * in_d;
      s1_gh_q <= grav_q * in_habs;
      s1_st_q <= (in_v == '0 || in_d == '0) ? ST_BAD : ST_OK;
    end
  end

  // ---------------- stage 2: wide products ----------------
  logic               s2_vld_q;
  logic [15:0]        s2_v_q, s2_d_q;
  logic               s2_hneg_q;
  logic [31:0]        s2_v2_q;
  logic [63:0]        s2_vv_q, s2_gg_q, s2_ghv_q;
  logic [47:0]        s2_gdd_q;
  logic signed [48:0] s2_hv2_q;
  logic [1:0]         s2_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_v_q    <= s1_v_q;
      s2_d_q    <= s1_d_q;
      s2_hneg_q <= s1_h_q[15];
      s2_v2_q   <= s1_v2_q;
      s2_vv_q   <= s1_v2_q * s1_v2_q;
      s2_gg_q   <= s1_gd_q * s1_gd_q;
      s2_ghv_q  <= s1_gh_q * s1_v2_q;
      s2_gdd_q  <= s1_gd_q * s1_d_q;
      s2_hv2_q  <= s1_h_q * $signed({1'b0, s1_v2_q});
      s2_st_q   <= s1_st_q;
    end
  end

  // ---------------- stage 3: discriminant and tangent numerator ----------------
  logic signed [64:0]    q_a, q_b, q_x, q30;
  logic signed [N_W-1:0] n28;
  assign q_a = $signed({3'b0, s2_vv_q[63:2]});
  assign q_b = $signed({11'b0, s2_gg_q[63:10]});
  assign q_x = $signed({6'b0, s2_ghv_q[63:5]});
  assign q30 = s2_hneg_q ? (q_a - q_b + q_x) : (q_a - q_b - q_x);
  assign n28 = $signed({6'b0, s2_gdd_q}) + (N_W'(s2_hv2_q) <<< 5);

  logic             s3_vld_q;
  logic [RAD_W-1:0] s3_rad_q;
  sqrt_side_t       s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rad_q          <= q30[64] ? '0 : q30[RAD_W-1:0];
      s3_side_q.status  <= (s2_st_q == ST_OK && q30[64]) ? ST_UNREACH : s2_st_q;
      s3_side_q.speed   <= s2_v_q;
      s3_side_q.range_m <= s2_d_q;
      s3_side_q.v2      <= s2_v2_q;
      s3_side_q.n28     <= n28;
    end
  end

  // ---------------- square root ----------------
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sqrt_side_t        sq_side;

  bps_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // ---------------- stage 4: v^2 + sqrt(Q) ----------------
  logic           s4_vld_q;
  logic [P_W-1:0] s4_p_q;
  sqrt_side_t     s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_p_q    <= {2'b0, sq_side.v2} + {1'b0, sq_root, 1'b0};
      s4_side_q <= sq_side;
    end
  end

  // ---------------- stage 5: tangent denominator and time divisor ----------------
  logic [DEN_W-1:0] dp;
  assign dp = s4_side_q.range_m * s4_p_q;

  logic                   s5_vld_q;
  logic signed [XY_W-1:0] s5_x_q, s5_y_q;
  cordic_side_t           s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_x_q           <= $signed({4'b0, dp, 4'b0});
      s5_y_q           <= XY_W'(s4_side_q.n28);
      s5_side_q.status <= s4_side_q.status;
      s5_side_q.den    <= s4_side_q.speed * s4_p_q;
    end
  end

  // ---------------- CORDIC: angle and magnitude ----------------
  logic                   cr_vld;
  logic signed [XY_W-1:0] cr_x;
  logic signed [Z_W-1:0]  cr_z;
  cordic_side_t           cr_side;

  bps_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_vld_q),
    .x_i     (s5_x_q),
    .y_i     (s5_y_q),
    .side_i  (s5_side_q),
    .valid_o (cr_vld),
    .x_o     (cr_x),
    .z_o     (cr_z),
    .side_o  (cr_side)
  );

  // ---------------- stage 6: round pitch, remove CORDIC gain ----------------
  logic signed [Z_W-1:0] zr;
  logic signed [15:0]    pitch;
  logic [XY_W-2:0]       mag;
  assign zr  = (cr_z + Z_W'(2)) >>> 2;
  assign mag = cr_x[XY_W-1] ? '0 : cr_x[XY_W-2:0];

  always_comb begin
    if (zr > Z_W'(PITCH_LIMIT)) begin
      pitch = 16'(PITCH_LIMIT);
    end else if (zr < -Z_W'(PITCH_LIMIT)) begin
      pitch = -16'(PITCH_LIMIT);
    end else begin
      pitch = zr[15:0];
    end
  end

  logic             s6_vld_q;
  logic [56:0]      s6_hi_q;
  logic [15:0]      s6_lo_q;
  logic [31:0]      lo_prod;
  logic [15:0]      s6_pitch_q;
  logic [1:0]       s6_st_q;
  logic [DEN_W-1:0] s6_den_q;
  assign lo_prod = {16'b0, mag[15:0]} * {16'b0, INV_GAIN};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= cr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_hi_q    <= {16'b0, mag[XY_W-2:16]} * {41'b0, INV_GAIN};
      s6_lo_q    <= lo_prod[31:16];
      s6_pitch_q <= pitch;
      s6_st_q    <= cr_side.status;
      s6_den_q   <= cr_side.den;
    end
  end

  // ---------------- stage 7: dividend ----------------
  logic             s7_vld_q;
  logic [65:0]      s7_num_q;
  logic [57:0]      csum;
  logic [15:0]      s7_pitch_q;
  logic [1:0]       s7_st_q;
  logic [DEN_W-1:0] s7_den_q;
  assign csum = {1'b0, s6_hi_q} + {42'b0, s6_lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_num_q   <= {csum, 8'b0};
      s7_pitch_q <= s6_pitch_q;
      s7_st_q    <= s6_st_q;
      s7_den_q   <= s6_den_q;
    end
  end

  // ---------------- stage 8: flight time overflow check ----------------
  logic             s8_vld_q;
  logic [65:0]      s8_rem_q;
  logic [15:0]      s8_pitch_q;
  logic [1:0]       s8_st_q;
  logic [DEN_W-1:0] s8_den_q;
  logic             ovf;
  assign ovf = s7_num_q >= {s7_den_q, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_rem_q   <= s7_num_q;
      s8_pitch_q <= s7_pitch_q;
      s8_st_q    <= (s7_st_q == ST_OK && ovf) ? ST_OVF : s7_st_q;
      s8_den_q   <= s7_den_q;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic             dv_vld_q   [QUO_BITS];
  logic [65:0]      dv_rem_q   [QUO_BITS];
  logic [15:0]      dv_quo_q   [QUO_BITS];
  logic [15:0]      dv_pitch_q [QUO_BITS];
  logic [1:0]       dv_st_q    [QUO_BITS];
  logic [DEN_W-1:0] dv_den_q   [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    localparam int K = QUO_BITS - 1 - i;
    logic             vin;
    logic [65:0]      rin, trial;
    logic [15:0]      qin, pin;
    logic [1:0]       sin;
    logic [DEN_W-1:0] din;
    logic             take;

    if (i == 0) begin : g_first
      assign vin = s8_vld_q;
      assign rin = s8_rem_q;
      assign qin = '0;
      assign pin = s8_pitch_q;
      assign sin = s8_st_q;
      assign din = s8_den_q;
    end else begin : g_next
      assign vin = dv_vld_q[i-1];
      assign rin = dv_rem_q[i-1];
      assign qin = dv_quo_q[i-1];
      assign pin = dv_pitch_q[i-1];
      assign sin = dv_st_q[i-1];
      assign din = dv_den_q[i-1];
    end

    assign trial = {16'b0, din} << K;
    assign take  = rin >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[i] <= 1'b0;
      end else if (en) begin
        dv_vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[i]   <= take ? rin - trial : rin;
        dv_quo_q[i]   <= take ? (qin | (16'(1) << K)) : qin;
        dv_pitch_q[i] <= pin;
        dv_st_q[i]    <= sin;
        dv_den_q[i]   <= din;
      end
    end
  end

  // The last divider stage doubles as the output register.
  assign out_vld       = dv_vld_q[QUO_BITS-1];
  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = dv_st_q[QUO_BITS-1];
  assign m_axis_tdata  = (dv_st_q[QUO_BITS-1] == ST_OK)
                       ? {dv_quo_q[QUO_BITS-1], dv_pitch_q[QUO_BITS-1]} : '0;

endmodule

// ===== design/bps_checker.sv =====
// Port-level checks for the ballistic pitch solver, bound to the top level.
// Depends on bps_pkg and ballistic_pitch_solver_core.
module bps_checker import bps_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Failed solutions carry zero pitch and time.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("failed result carries non-zero data");

  // Pitch stays inside its limit.
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_OK |->
      $signed(m_axis_tdata[15:0]) <= $signed(16'(PITCH_LIMIT)) &&
      $signed(m_axis_tdata[15:0]) >= -$signed(16'(PITCH_LIMIT)))
    else $error("pitch out of range");

  // A draining output never blocks the input side.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind ballistic_pitch_solver_core bps_checker u_bps_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for ballistic_pitch_solver_core: drives query beats,
// predicts each launch solution in-bench and checks every result beat.
// Depends on bps_pkg (status codes, reset gravity) and the core RTL.
module tb_top;
  import bps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]        speed;
    logic [15:0]        dist_m;
    logic signed [15:0] height;
  } query_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] pitch;
    logic [15:0] tof;
  } solution_t;

  localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  query_t      query_q[$];
  solution_t   solution_q[$];
  logic [15:0] grav_model = GRAV_RESET;
  int          src_idle = 30;
  int          snk_idle = 73;
  bit          snk_hold = 1'b0;
  int          n_errors = 0;
  int          n_sent = 0;

  always #1 clk_i = ~clk_i;

  ballistic_pitch_solver_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Work out one launch solution at the block's fixed-point scales.
  function automatic solution_t solve_launch(query_t q, logic [15:0] grav);
    solution_t    sol;
    longint unsigned v, d, g, hmag, v2, gd, ghv, rem, root, bitv, p16, r, c, den, tq;
    longint       h, q30, n28, m28, x, y, z, dx, dy, pitch;
    sol = '{ST_OK, 16'd0, 16'd0};
    v = q.speed;
    d = q.dist_m;
    g = grav;
    h = q.height;
    hmag = (h < 0) ? -h : h;
    if (v == 0 || d == 0) begin
      sol.status = ST_BAD;
      return sol;
    end
    v2 = v * v;
    gd = g * d;
    ghv = g * hmag * v2;
    q30 = longint'((v2 * v2) >> 2) - longint'((gd * gd) >> 10);
    if (h < 0) q30 += longint'(ghv >> 5);
    else q30 -= longint'(ghv >> 5);
    if (q30 < 0) begin
      sol.status = ST_UNREACH;
      return sol;
    end
    // digit-by-digit integer square root
    rem = q30;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    p16 = v2 + 2 * root;
    n28 = longint'(gd * d) + 32 * h * longint'(v2);
    m28 = longint'(16 * d * p16);
    x = m28;
    y = n28;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ARCTAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN_Q16[i];
      end
    end
    pitch = (z + 2) >>> 2;
    if (pitch > PITCH_LIMIT) pitch = PITCH_LIMIT;
    if (pitch < -PITCH_LIMIT) pitch = -PITCH_LIMIT;
    r = (x < 0) ? 0 : x;
    c = (r >> 16) * 39797 + (((r & 64'hFFFF) * 39797) >> 16);
    den = v * p16;
    tq = (c * 256) / den;
    if (tq > 64'hFFFF) begin
      sol.status = ST_OVF;
      return sol;
    end
    sol.pitch = pitch[15:0];
    sol.tof = tq[15:0];
    return sol;
  endfunction

  // Driver: hold a beat until taken, then offer the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        solution_q = {solution_q, solve_launch(query_q[0], grav_model)};
        query_q.delete(0);
        n_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (query_q.size() > 0 && $urandom_range(99) >= src_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {query_q[0].height, query_q[0].dist_m, query_q[0].speed};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: stall at random, compare each result beat with the oldest solution.
  always @(posedge clk_i) begin
    solution_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (solution_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h tuser %0d",
                 m_axis_tdata, m_axis_tuser);
          n_errors++;
        end else begin
          want = solution_q[0];
          solution_q.delete(0);
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, m_axis_tuser);
            n_errors++;
          end
          if (m_axis_tdata[15:0] !== want.pitch) begin
            $error("pitch_angle: expected %0d actual %0d",
                   $signed(want.pitch), $signed(m_axis_tdata[15:0]));
            n_errors++;
          end
          if (m_axis_tdata[31:16] !== want.tof) begin
            $error("flight_time: expected %0d actual %0d", want.tof, m_axis_tdata[31:16]);
            n_errors++;
          end
        end
      end
      m_axis_tready <= !snk_hold && ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic add_query(input logic [15:0] v, input logic [15:0] d, input logic [15:0] h);
    query_q = {query_q, query_t'{v, d, h}};
  endtask

  // Mostly plausible shots, the rest raw noise over the full field ranges.
  task automatic add_random(input int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) == 0)
        add_query(16'($urandom), 16'($urandom), 16'($urandom));
      else
        add_query(16'($urandom_range(20000, 1500)), 16'($urandom_range(25000, 1)),
                  16'($signed($urandom_range(6000)) - 3000));
    end
  endtask

  task automatic drain();
    wait (query_q.size() == 0 && solution_q.size() == 0);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic set_gravity(input logic [15:0] g);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    grav_model  = g;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: bad input, extremes, unreachable and overflow shots
    add_query(16'd0, 16'd1000, 16'd0);
    add_query(16'd5000, 16'd0, 16'd0);
    add_query(16'd0, 16'd0, 16'h8000);
    add_query(16'hFFFF, 16'hFFFF, 16'h7FFF);
    add_query(16'hFFFF, 16'hFFFF, 16'h8000);
    add_query(16'hFFFF, 16'd1, 16'd0);
    add_query(16'd1, 16'd1, 16'd0);
    add_query(16'd1, 16'hFFFF, 16'h8000);
    add_query(16'd256, 16'hFFFF, 16'd0);
    add_query(16'd12800, 16'd25600, 16'd0);
    add_query(16'd12800, 16'd25600, 16'd2560);
    add_query(16'd12800, 16'd25600, -16'sd2560);
    add_query(16'd600, 16'd2000, -16'sd32768);
    add_query(16'd300, 16'd40000, 16'd100);
    add_query(16'd20000, 16'd100, 16'h7FFF);
    add_query(16'd20000, 16'd100, 16'h8000);
    add_query(16'd5000, 16'd5000, 16'd1);
    add_query(16'd5000, 16'd5000, 16'hFFFF);
    drain();

    add_random(150);
    drain();
    set_gravity(16'd0);           // straight-line aim
    add_random(120);
    drain();

    src_idle = 73;
    snk_idle = 30;
    set_gravity(16'hFFFF);
    add_random(120);
    drain();
    set_gravity(16'($urandom));
    // long sink stall while the sender keeps offering: fill the pipeline
    snk_hold = 1'b1;
    add_random(150);
    repeat (400) @(posedge clk_i);
    snk_hold = 1'b0;
    drain();

    src_idle = 0;
    snk_idle = 0;
    set_gravity(16'd1);
    add_random(150);
    drain();
    set_gravity(GRAV_RESET);
    add_random(150);
    drain();

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bps_pkg.sv
design/bps_isqrt.sv
design/bps_cordic.sv
design/ballistic_pitch_solver_core.sv
design/bps_checker.sv
tb/tb_top.sv
